// ----- rtl/dtmd_pkg.sv -----
// Shared types and constants for the dot-terminated message deframer.
// Used by the front classifier, the run queue, the back serializer and the top level.
// No dependencies.
package dtmd_pkg;

  // Framing characters
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DOT = 8'h2E;

  // Most results one input byte can release
  localparam int unsigned RUN_MAX = 4;
  localparam int unsigned RUN_CW  = $clog2(RUN_MAX + 1);
  localparam int unsigned RUN_IW  = $clog2(RUN_MAX);

  // Run queue between front and back
  localparam int unsigned RUNQ_DEPTH = 4;
  localparam int unsigned RUNQ_AW    = $clog2(RUNQ_DEPTH);
  localparam int unsigned RUNQ_CW    = $clog2(RUNQ_DEPTH + 1);

  // One result: a content byte or a message end marker
  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
  } entry_t;

  // All results caused by one input byte, entry 0 first
  typedef struct packed {
    logic [RUN_CW-1:0]       cnt;
    entry_t [RUN_MAX-1:0]    ent;
  } run_t;

endpackage

// ----- rtl/dtmd_front.sv -----
// Front classifier: tracks the held terminator prefix and turns each input byte
// into a run of results. Depends on dtmd_pkg.
module dtmd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                acc,
  input  logic [7:0]          in_byte,
  output dtmd_pkg::run_t      run,
  output logic                run_valid
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_CR       = 3'd1,
    PH_CRLF     = 3'd2,
    PH_CRLFD    = 3'd3,
    PH_CRLFDCR  = 3'd4,
    PH_LF       = 3'd5,
    PH_LFD      = 3'd6
  } phase_t;

  phase_t phase, phase_next;

  function automatic dtmd_pkg::entry_t byte_ent(input logic [7:0] b);
    dtmd_pkg::entry_t e;
    e.is_end = 1'b0;
    e.data   = b;
    return e;
  endfunction

  function automatic dtmd_pkg::entry_t end_ent();
    dtmd_pkg::entry_t e;
    e.is_end = 1'b1;
    e.data   = 8'h00;
    return e;
  endfunction

  logic is_cr, is_lf, is_dot;
  assign is_cr  = (in_byte == dtmd_pkg::CH_CR);
  assign is_lf  = (in_byte == dtmd_pkg::CH_LF);
  assign is_dot = (in_byte == dtmd_pkg::CH_DOT);

  // Next phase and released results; a stuffed dot held after LF is never released
  always_comb begin
    run        = '0;
    phase_next = phase;
    unique case (phase) inside
      PH_CR: begin
        if (is_lf) begin
          phase_next = PH_CRLF;
        end else if (is_cr) begin
          run.cnt    = dtmd_pkg::RUN_CW'(1);
          run.ent[0] = byte_ent(dtmd_pkg::CH_CR);
        end else begin
          run.cnt    = dtmd_pkg::RUN_CW'(2);
          run.ent[0] = byte_ent(dtmd_pkg::CH_CR);
          run.ent[1] = byte_ent(in_byte);
          phase_next = PH_IDLE;
        end
      end
      PH_CRLF: begin
        run.ent[0] = byte_ent(dtmd_pkg::CH_CR);
        run.ent[1] = byte_ent(dtmd_pkg::CH_LF);
        run.ent[2] = byte_ent(in_byte);
        if (is_dot) begin
          run.cnt    = '0;
          phase_next = PH_CRLFD;
        end else if (is_cr) begin
          run.cnt    = dtmd_pkg::RUN_CW'(2);
          phase_next = PH_CR;
        end else if (is_lf) begin
          run.cnt    = dtmd_pkg::RUN_CW'(2);
          phase_next = PH_LF;
        end else begin
          run.cnt    = dtmd_pkg::RUN_CW'(3);
          phase_next = PH_IDLE;
        end
      end
      PH_CRLFD: begin
        if (is_cr) begin
          phase_next = PH_CRLFDCR;
        end else if (is_lf) begin
          // LF form ends first: leading CR is content
          run.cnt    = dtmd_pkg::RUN_CW'(2);
          run.ent[0] = byte_ent(dtmd_pkg::CH_CR);
          run.ent[1] = end_ent();
          phase_next = PH_IDLE;
        end else begin
          run.cnt    = dtmd_pkg::RUN_CW'(3);
          run.ent[0] = byte_ent(dtmd_pkg::CH_CR);
          run.ent[1] = byte_ent(dtmd_pkg::CH_LF);
          run.ent[2] = byte_ent(in_byte);
          phase_next = PH_IDLE;
        end
      end
      PH_CRLFDCR: begin
        if (is_lf) begin
          run.cnt    = dtmd_pkg::RUN_CW'(1);
          run.ent[0] = end_ent();
          phase_next = PH_IDLE;
        end else begin
          run.ent[0] = byte_ent(dtmd_pkg::CH_CR);
          run.ent[1] = byte_ent(dtmd_pkg::CH_LF);
          run.ent[2] = byte_ent(dtmd_pkg::CH_CR);
          run.ent[3] = byte_ent(in_byte);
          if (is_cr) begin
            run.cnt    = dtmd_pkg::RUN_CW'(3);
            phase_next = PH_CR;
          end else begin
            run.cnt    = dtmd_pkg::RUN_CW'(4);
            phase_next = PH_IDLE;
          end
        end
      end
      PH_LF, PH_LFD: begin
        run.ent[0] = byte_ent(dtmd_pkg::CH_LF);
        run.ent[1] = byte_ent(in_byte);
        if (phase == PH_LF && is_dot) begin
          phase_next = PH_LFD;
        end else if (phase == PH_LFD && is_lf) begin
          run.cnt    = dtmd_pkg::RUN_CW'(1);
          run.ent[0] = end_ent();
          phase_next = PH_IDLE;
        end else if (is_cr) begin
          run.cnt    = dtmd_pkg::RUN_CW'(1);
          phase_next = PH_CR;
        end else if (is_lf) begin
          run.cnt    = dtmd_pkg::RUN_CW'(1);
          phase_next = PH_LF;
        end else begin
          run.cnt    = dtmd_pkg::RUN_CW'(2);
          phase_next = PH_IDLE;
        end
      end
      default: begin
        // idle, and the unused code
        run.ent[0] = byte_ent(in_byte);
        if (is_cr) begin
          phase_next = PH_CR;
        end else if (is_lf) begin
          phase_next = PH_LF;
        end else begin
          run.cnt    = dtmd_pkg::RUN_CW'(1);
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  assign run_valid = acc && (run.cnt != '0);

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (acc) begin
      phase <= phase_next;
    end
  end

endmodule

// ----- rtl/dtmd_run_fifo.sv -----
// Short queue of result runs between the front classifier and the back serializer.
// Depends on dtmd_pkg.
module dtmd_run_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  dtmd_pkg::run_t   wr_data,
  output logic             full,
  input  logic             rd_en,
  output dtmd_pkg::run_t   rd_data,
  output logic             empty
);

  dtmd_pkg::run_t                 store [dtmd_pkg::RUNQ_DEPTH];
  logic [dtmd_pkg::RUNQ_AW-1:0]   wr_ptr, rd_ptr;
  logic [dtmd_pkg::RUNQ_CW-1:0]   count;
  logic                           do_wr, do_rd;

  assign full    = (count == dtmd_pkg::RUNQ_CW'(dtmd_pkg::RUNQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/dtmd_back.sv -----
// Back serializer: walks the head run one result per cycle into the output register
// while pop is high or the register is empty. Depends on dtmd_pkg.
module dtmd_back (
  input  logic             clk,
  input  logic             rst,
  input  dtmd_pkg::run_t   run,
  input  logic             run_empty,
  output logic             run_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             message_end,
  output logic             last_of_run
);

  logic [dtmd_pkg::RUN_IW-1:0] idx;
  logic                        out_valid;
  logic                        advance, load, at_last;
  dtmd_pkg::entry_t            cur;

  assign advance = !out_valid || pop;
  assign load    = advance && !run_empty;
  assign cur     = run.ent[idx];
  assign at_last = ({1'b0, idx} == (run.cnt - 1'b1));
  assign run_pop = load && at_last;
  assign empty   = !out_valid;

  // Control: position in the run and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= !run_empty;
      if (load) begin
        idx <= at_last ? '0 : idx + 1'b1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= cur.data;
      byte_valid  <= !cur.is_end;
      message_end <= cur.is_end;
      last_of_run <= at_last;
    end
  end

endmodule

// ----- rtl/dot_terminated_message_deframer.sv -----
// Dot-terminated message deframer top level: front classifier, run queue, back serializer.
// Depends on dtmd_pkg, dtmd_front, dtmd_run_fifo and dtmd_back.
//
// Usage:
//   Input channel: drive in_byte with push high; the byte is taken at a clock edge where
//   full is low. One raw byte per cycle is accepted while the run queue has room.
//   Result channel: while empty is low, out_byte/byte_valid/message_end/last_of_run hold
//   the oldest result; pulse pop to take it. A message end is a result with byte_valid
//   low and message_end high. last_of_run marks the final result caused by one byte.
//   With the result side idle, the first result of a byte is written into the run queue
//   and then loaded into the output register that drives the ports.
//   Throughput: one byte per cycle in, one result per cycle out while pop is high. A byte
//   that releases n results (n is at most 4) holds the result side until all are taken;
//   bytes that only extend a held terminator prefix do not occupy it. The four-entry
//   run queue absorbs such bursts; full rises when it is exhausted.
//   Stall: while pop is low the output register holds and the queue fills, then full
//   holds the sender off. Bytes of an unfinished terminator prefix stay held until later
//   bytes decide them.
//   Reset (rst, synchronous): clears the held prefix, the queue and the output register.
module dot_terminated_message_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       message_end,
  output logic       last_of_run,
  output logic       empty,
  input  logic       pop
);

  dtmd_pkg::run_t fr_run, q_run;
  logic           fr_valid, q_empty, q_pop, acc;

  // Input transaction
  assign acc = push && !full;

  dtmd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .in_byte   (in_byte),
    .run       (fr_run),
    .run_valid (fr_valid)
  );

  dtmd_run_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fr_valid),
    .wr_data (fr_run),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_run),
    .empty   (q_empty)
  );

  dtmd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .run         (q_run),
    .run_empty   (q_empty),
    .run_pop     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .message_end (message_end),
    .last_of_run (last_of_run)
  );

endmodule

// ----- dv/tb.sv -----
// Testbench for dot_terminated_message_deframer: directed and random byte streams with
// independent sender and receiver pacing, each result checked against an internal predictor.
// Depends on dtmd_pkg and the RTL of the deframer.
`timescale 1ns / 1ps

module tb;

  // Which terminator prefix the predictor holds back
  typedef enum logic [2:0] {
    PH_IDLE, PH_CR, PH_CR_LF, PH_CR_LF_DOT, PH_CR_LF_DOT_CR, PH_LF, PH_LF_DOT
  } phase_t;

  // One result transaction as seen on the output ports
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       mend;
    logic       last;
  } result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] in_byte = 8'h00;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       message_end;
  logic       last_of_run;
  logic       empty;

  // Pacing knobs (the _pct knobs in percent of cycles, hold_req a receiver hold-off length) and counters
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned bytes_sent = 0;
  int unsigned fail_count = 0;

  // Predictor state
  phase_t  held_phase = PH_IDLE;
  logic    msg_start = 1'b1;
  logic    prev_lf = 1'b0;
  result_t byte_results[$];
  result_t expected_q[$];

  dot_terminated_message_deframer u_top (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .push        (push),
    .full        (full),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .message_end (message_end),
    .last_of_run (last_of_run),
    .empty       (empty),
    .pop         (pop)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void add_result(input logic [7:0] b, input logic v, input logic e);
    result_t r;
    r.data  = b;
    r.valid = v;
    r.mend  = e;
    r.last  = 1'b0;
    if (byte_results.size() < dtmd_pkg::RUN_MAX + 1) byte_results.push_back(r);
  endfunction

  // Release one held or passed-through content byte; a dot right after LF is unstuffed
  function automatic void release_byte(input logic [7:0] b);
    if (!(b == dtmd_pkg::CH_DOT && prev_lf && !msg_start)) add_result(b, 1'b1, 1'b0);
    prev_lf   = (b == dtmd_pkg::CH_LF);
    msg_start = 1'b0;
  endfunction

  function automatic void close_message();
    add_result(8'h00, 1'b0, 1'b1);
    held_phase = PH_IDLE;
    msg_start  = 1'b1;
    prev_lf    = 1'b0;
  endfunction

  // Works out every result one accepted byte causes and queues them as expected
  function automatic void deframe_byte(input logic [7:0] x);
    int unsigned scan_q[$];
    logic [7:0]  c;
    int unsigned d;
    logic        rescan;
    byte_results.delete();
    prev_lf = 1'b0;
    scan_q.push_back(x);
    while (scan_q.size() > 0) begin
      c = scan_q[0][7:0];
      d = scan_q[0] >> 8;
      void'(scan_q.pop_front());
      rescan = 1'b0;
      if (d > 3) begin
        release_byte(c);
      end else begin
        case (held_phase)
          PH_CR: begin
            if (c == dtmd_pkg::CH_LF) held_phase = PH_CR_LF;
            else begin
              release_byte(dtmd_pkg::CH_CR);
              rescan = 1'b1;
            end
          end
          PH_CR_LF: begin
            if (c == dtmd_pkg::CH_DOT) held_phase = PH_CR_LF_DOT;
            else begin
              release_byte(dtmd_pkg::CH_CR);
              release_byte(dtmd_pkg::CH_LF);
              rescan = 1'b1;
            end
          end
          PH_CR_LF_DOT: begin
            if (c == dtmd_pkg::CH_CR) held_phase = PH_CR_LF_DOT_CR;
            else if (c == dtmd_pkg::CH_LF) begin
              // LF form inside the CRLF prefix wins; the CR is content
              release_byte(dtmd_pkg::CH_CR);
              close_message();
            end else begin
              release_byte(dtmd_pkg::CH_CR);
              release_byte(dtmd_pkg::CH_LF);
              release_byte(dtmd_pkg::CH_DOT);
              rescan = 1'b1;
            end
          end
          PH_CR_LF_DOT_CR: begin
            if (c == dtmd_pkg::CH_LF) close_message();
            else begin
              // Last CR may start a new prefix: scan it, then the new byte
              release_byte(dtmd_pkg::CH_CR);
              release_byte(dtmd_pkg::CH_LF);
              release_byte(dtmd_pkg::CH_DOT);
              held_phase = PH_IDLE;
              scan_q.push_front(((d + 1) << 8) | c);
              scan_q.push_front(((d + 1) << 8) | dtmd_pkg::CH_CR);
            end
          end
          PH_LF: begin
            if (c == dtmd_pkg::CH_DOT) held_phase = PH_LF_DOT;
            else begin
              release_byte(dtmd_pkg::CH_LF);
              rescan = 1'b1;
            end
          end
          PH_LF_DOT: begin
            if (c == dtmd_pkg::CH_LF) close_message();
            else begin
              release_byte(dtmd_pkg::CH_LF);
              release_byte(dtmd_pkg::CH_DOT);
              rescan = 1'b1;
            end
          end
          default: begin
            if (c == dtmd_pkg::CH_CR) held_phase = PH_CR;
            else if (c == dtmd_pkg::CH_LF) held_phase = PH_LF;
            else begin
              held_phase = PH_IDLE;
              release_byte(c);
            end
          end
        endcase
      end
      if (rescan) begin
        held_phase = PH_IDLE;
        scan_q.push_front(((d + 1) << 8) | c);
      end
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[i]) expected_q.push_back(byte_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at a falling edge with push low
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push    = 1'b0;
      in_byte = 8'($urandom_range(255));
      @(negedge clk);
    end
    push    = 1'b1;
    in_byte = b;
    do @(posedge clk); while (full);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
    push = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pops at random, honors hold-off requests, checks each transaction
  // ---------------------------------------------------------------------------

  initial begin : result_side
    int unsigned hold_left;
    result_t     exp_r;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (!rst && pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: out_byte %h byte_valid %b message_end %b",
                 out_byte, byte_valid, message_end);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_byte !== exp_r.data) begin
            $error("out_byte: expected %h, got %h", exp_r.data, out_byte);
            fail_count++;
          end
          if (byte_valid !== exp_r.valid) begin
            $error("byte_valid: expected %b, got %b", exp_r.valid, byte_valid);
            fail_count++;
          end
          if (message_end !== exp_r.mend) begin
            $error("message_end: expected %b, got %b", exp_r.mend, message_end);
            fail_count++;
          end
          if (last_of_run !== exp_r.last) begin
            $error("last_of_run: expected %b, got %b", exp_r.last, last_of_run);
            fail_count++;
          end
        end
      end
      @(negedge clk);
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Both terminator forms, the empty message and the CR LF dot LF overlap
  task automatic test_terminators();
    send_byte(dtmd_pkg::CH_CR); send_byte(dtmd_pkg::CH_LF); send_byte(dtmd_pkg::CH_DOT);
    send_byte(dtmd_pkg::CH_CR); send_byte(dtmd_pkg::CH_LF);
    send_byte(8'h41); send_byte(dtmd_pkg::CH_LF); send_byte(dtmd_pkg::CH_DOT);
    send_byte(dtmd_pkg::CH_LF);
    send_byte(dtmd_pkg::CH_CR); send_byte(dtmd_pkg::CH_LF); send_byte(dtmd_pkg::CH_DOT);
    send_byte(dtmd_pkg::CH_LF);
  endtask

  // Leading dot of a message is kept; a dot after a newline is dropped
  task automatic test_dot_unstuffing();
    send_byte(dtmd_pkg::CH_DOT); send_byte(dtmd_pkg::CH_LF); send_byte(dtmd_pkg::CH_DOT);
    send_byte(dtmd_pkg::CH_DOT); send_byte(8'h79);
  endtask

  // CR LF dot CR that fails on its last byte, then a doubled CR
  task automatic test_held_prefixes();
    send_byte(dtmd_pkg::CH_CR); send_byte(dtmd_pkg::CH_LF); send_byte(dtmd_pkg::CH_DOT);
    send_byte(dtmd_pkg::CH_CR); send_byte(8'h7A);
    send_byte(dtmd_pkg::CH_CR); send_byte(dtmd_pkg::CH_CR); send_byte(8'h7A);
  endtask

  task automatic test_byte_extremes();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // Receiver holds off long enough for the queue to fill and full to rise
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 80;
    for (int i = 0; i < 20; i++) send_byte(8'h61 + i[7:0]);
  endtask

  function automatic logic [7:0] text_byte();
    case ($urandom_range(9)) inside
      0:       return dtmd_pkg::CH_CR;
      1:       return dtmd_pkg::CH_LF;
      2, 3:    return dtmd_pkg::CH_DOT;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly framed traffic with stuffing and near-miss terminators, some raw noise
  task automatic test_random_traffic(input int unsigned n_bytes, input int unsigned s_pct,
                                     input int unsigned r_pct);
    int unsigned goal;
    int unsigned k;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      case ($urandom_range(9)) inside
        0, 1, 2, 3: repeat ($urandom_range(1, 8)) send_byte(text_byte());
        4: begin
          send_byte(dtmd_pkg::CH_CR); send_byte(dtmd_pkg::CH_LF);
          send_byte(dtmd_pkg::CH_DOT); send_byte(dtmd_pkg::CH_CR);
          send_byte(dtmd_pkg::CH_LF);
        end
        5: begin
          send_byte(dtmd_pkg::CH_LF); send_byte(dtmd_pkg::CH_DOT);
          send_byte(dtmd_pkg::CH_LF);
        end
        6: begin
          send_byte(dtmd_pkg::CH_LF); send_byte(dtmd_pkg::CH_DOT);
          send_byte(dtmd_pkg::CH_DOT); send_byte(text_byte());
        end
        7: begin
          k = $urandom_range(1, 4);
          if (k >= 1) send_byte(dtmd_pkg::CH_CR);
          if (k >= 2) send_byte(dtmd_pkg::CH_LF);
          if (k >= 3) send_byte(dtmd_pkg::CH_DOT);
          if (k >= 4) send_byte(dtmd_pkg::CH_CR);
          send_byte(text_byte());
        end
        8: begin
          send_byte(dtmd_pkg::CH_LF); send_byte(dtmd_pkg::CH_DOT); send_byte(text_byte());
        end
        default: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_terminators();
    test_dot_unstuffing();
    test_held_prefixes();
    test_byte_extremes();
    test_backpressure();
    test_random_traffic(96, 0, 0);
    test_random_traffic(96, 85, 0);
    test_random_traffic(96, 0, 85);
    test_random_traffic(96, 24, 24);

    // Drain, then watch a little longer for stray results
    recv_stall_pct = 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dtmd_pkg.sv
rtl/dtmd_front.sv
rtl/dtmd_run_fifo.sv
rtl/dtmd_back.sv
rtl/dot_terminated_message_deframer.sv
dv/tb.sv
